// File: hdl/aeske_pkg.sv
package aeske_pkg;

	// key size codes
	localparam logic [1:0] SIZE_128 = 2'd0;
	localparam logic [1:0] SIZE_192 = 2'd1;
	localparam logic [1:0] SIZE_256 = 2'd2;
	localparam logic [1:0] SIZE_BAD = 2'd3;

	// round constant start value and reduction polynomial
	localparam logic [7:0] RCON_INIT = 8'h01;
	localparam logic [7:0] RCON_POLY = 8'h1B;

	// forward s-box
	localparam logic [7:0] SBOX [0:255] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// byte-wise s-box substitution of one word
	function automatic logic [31:0] sub_word(input logic [31:0] x);
		return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
	endfunction

	// rotate one byte to the left
	function automatic logic [31:0] rot_word(input logic [31:0] x);
		return {x[23:0], x[31:24]};
	endfunction

	// multiply by x in GF(2^8)
	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? RCON_POLY : 8'h00);
	endfunction

	// commands from controller to datapath
	typedef struct packed {
		logic       load;      // capture the cipher key
		logic       step;      // produce one schedule word
		logic       use_key;   // word comes straight from the key
		logic       rot_sub;   // rotate, substitute, add round constant
		logic       sub_only;  // substitute only (256-bit keys)
		logic [1:0] size;      // key size code of the running key
		logic [5:0] idx;       // index of the word produced
		logic       emit;      // word completes a round key
		logic       last;      // final round key
		logic [3:0] rounds;    // cipher round count
		logic       err_emit;  // emit the error result
	} cmd_t;

endpackage

// File: hdl/aeske_ctrl.sv
module aeske_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         key_size,
	output logic               busy,
	output aeske_pkg::cmd_t    cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic       state_q;
	logic [5:0] idx_q;
	logic [2:0] pos_q;
	logic [1:0] size_q;
	logic [2:0] nk_last;
	logic [5:0] idx_last;
	logic [3:0] nr;
	logic       use_key;
	logic       final_word;

	// per-size schedule figures
	always_comb begin
		unique case (size_q)
			aeske_pkg::SIZE_128: begin
				nk_last  = 3'd3;
				idx_last = 6'd43;
				nr       = 4'd10;
			end
			aeske_pkg::SIZE_192: begin
				nk_last  = 3'd5;
				idx_last = 6'd51;
				nr       = 4'd12;
			end
			default: begin
				nk_last  = 3'd7;
				idx_last = 6'd59;
				nr       = 4'd14;
			end
		endcase
	end

	assign use_key    = idx_q <= {3'b000, nk_last};
	assign final_word = idx_q == idx_last;
	assign busy       = state_q == ST_RUN;

	// commands
	always_comb begin
		cmd.load     = (state_q == ST_IDLE) && start;
		cmd.err_emit = (state_q == ST_IDLE) && start && (key_size == aeske_pkg::SIZE_BAD);
		cmd.step     = state_q == ST_RUN;
		cmd.use_key  = use_key;
		cmd.rot_sub  = !use_key && (pos_q == 3'd0);
		cmd.sub_only = !use_key && (size_q == aeske_pkg::SIZE_256) && (pos_q == 3'd4);
		cmd.size     = size_q;
		cmd.idx      = idx_q;
		cmd.emit     = (state_q == ST_RUN) && (idx_q[1:0] == 2'b11);
		cmd.last     = final_word;
		cmd.rounds   = nr;
	end

	// sequencer over the schedule words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			pos_q   <= '0;
			size_q  <= aeske_pkg::SIZE_128;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start && key_size != aeske_pkg::SIZE_BAD) begin
						state_q <= ST_RUN;
						idx_q   <= '0;
						pos_q   <= '0;
						size_q  <= key_size;
					end
				end
				default: begin
					idx_q <= idx_q + 6'd1;
					pos_q <= (pos_q == nk_last) ? 3'd0 : pos_q + 3'd1;
					if (final_word) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

endmodule

// File: hdl/aeske_dp.sv
module aeske_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  aeske_pkg::cmd_t    cmd,
	input  logic [63:0]        key_w0,
	input  logic [63:0]        key_w1,
	input  logic [63:0]        key_w2,
	input  logic [63:0]        key_w3,
	output logic               result_strobe,
	output logic [3:0]         round_index,
	output logic [63:0]        round_key_hi,
	output logic [63:0]        round_key_lo,
	output logic [3:0]         rounds,
	output logic               key_error,
	output logic               last
);

	logic [31:0] key_q [0:7];
	logic [31:0] win_q [0:7];
	logic [7:0]  rcon_q;
	logic [31:0] tap;
	logic [31:0] tmp;
	logic [31:0] new_word;
	logic        strobe_q;
	logic [3:0]  idx_out_q;
	logic [63:0] hi_q;
	logic [63:0] lo_q;
	logic [3:0]  rounds_q;
	logic        err_q;
	logic        last_q;

	// word nk places back
	always_comb begin
		unique case (cmd.size)
			aeske_pkg::SIZE_128: tap = win_q[3];
			aeske_pkg::SIZE_192: tap = win_q[5];
			default:             tap = win_q[7];
		endcase
	end

	// next schedule word
	always_comb begin
		priority if (cmd.rot_sub) begin
			tmp = aeske_pkg::sub_word(aeske_pkg::rot_word(win_q[0])) ^ {rcon_q, 24'h000000};
		end else if (cmd.sub_only) begin
			tmp = aeske_pkg::sub_word(win_q[0]);
		end else begin
			tmp = win_q[0];
		end
		new_word = cmd.use_key ? key_q[cmd.idx[2:0]] : (tap ^ tmp);
	end

	// key capture, word window and round constant
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q[0] <= key_w0[63:32];
			key_q[1] <= key_w0[31:0];
			key_q[2] <= key_w1[63:32];
			key_q[3] <= key_w1[31:0];
			key_q[4] <= key_w2[63:32];
			key_q[5] <= key_w2[31:0];
			key_q[6] <= key_w3[63:32];
			key_q[7] <= key_w3[31:0];
			rcon_q   <= aeske_pkg::RCON_INIT;
		end else if (cmd.step) begin
			win_q[0] <= new_word;
			for (int k = 1; k < 8; k++) begin
				win_q[k] <= win_q[k-1];
			end
			if (cmd.rot_sub) begin
				rcon_q <= aeske_pkg::xtime(rcon_q);
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit || cmd.err_emit;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.err_emit) begin
			idx_out_q <= '0;
			hi_q      <= '0;
			lo_q      <= '0;
			rounds_q  <= '0;
			err_q     <= 1'b1;
			last_q    <= 1'b1;
		end else if (cmd.emit) begin
			idx_out_q <= cmd.idx[5:2];
			hi_q      <= {win_q[2], win_q[1]};
			lo_q      <= {win_q[0], new_word};
			rounds_q  <= cmd.rounds;
			err_q     <= 1'b0;
			last_q    <= cmd.last;
		end
	end

	assign result_strobe = strobe_q;
	assign round_index   = idx_out_q;
	assign round_key_hi  = hi_q;
	assign round_key_lo  = lo_q;
	assign rounds        = rounds_q;
	assign key_error     = err_q;
	assign last          = last_q;

endmodule

// File: hdl/aes_key_expansion_top.sv
// AES key schedule generator for 128, 192 and 256 bit cipher keys.
// A key transfer happens at a clock edge with start high and busy low;
// key_size selects the key length and key_w0..key_w3 carry the key bytes.
// Round keys leave on round_key_hi/round_key_lo, each shown for exactly
// one cycle with result_strobe high, in round order, with round_index,
// rounds (10, 12 or 14) and last on the final round key.
// One 32-bit schedule word is produced per cycle by the datapath, and a
// key keeps the block busy until all 4 * (rounds + 1) words are made;
// each round key is registered as its fourth schedule word is produced.
// busy drops in the cycle of the last result, and a new key may be
// transferred in that cycle.
// An invalid size code gives one result, the cycle after the transfer,
// with key_error and last set and all other fields zero; busy stays low.
// The receiver cannot stall: every strobed result must be taken.
// Reset clears the sequencer and the strobe; no result is pending after it.
module aes_key_expansion_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  key_size,
	input  logic [63:0] key_w0,
	input  logic [63:0] key_w1,
	input  logic [63:0] key_w2,
	input  logic [63:0] key_w3,
	output logic        result_strobe,
	output logic [3:0]  round_index,
	output logic [63:0] round_key_hi,
	output logic [63:0] round_key_lo,
	output logic [3:0]  rounds,
	output logic        key_error,
	output logic        last
);

	aeske_pkg::cmd_t cmd;

	// sequencer
	aeske_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.key_size (key_size),
		.busy     (busy),
		.cmd      (cmd)
	);

	// schedule datapath
	aeske_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.key_w0        (key_w0),
		.key_w1        (key_w1),
		.key_w2        (key_w2),
		.key_w3        (key_w3),
		.result_strobe (result_strobe),
		.round_index   (round_index),
		.round_key_hi  (round_key_hi),
		.round_key_lo  (round_key_lo),
		.rounds        (rounds),
		.key_error     (key_error),
		.last          (last)
	);

	// the final result ends the busy period
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last |-> !busy)
		else $error("busy still high on final round key");

	// intermediate results only while the schedule runs
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last |-> busy)
		else $error("round key strobed outside a schedule run");

	// error result is single and empty
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && key_error |-> last && rounds == 4'd0 && round_index == 4'd0)
		else $error("malformed error result");

	// a valid key starts a run
	a_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && key_size != aeske_pkg::SIZE_BAD |=> busy)
		else $error("valid key did not start the schedule");

endmodule

// File: test/tb_aes_key_expansion_top.sv
module tb_aes_key_expansion_top;

	// own constants of the schedule predictor
	localparam logic [7:0] AFFINE_CONST = 8'h63;
	localparam logic [7:0] GF_POLY      = 8'h1B;
	localparam logic [7:0] RCON_FIRST   = 8'h01;
	localparam logic [7:0] INV3_FIX     = 8'h09;
	localparam int         RANDOM_KEYS  = 270;
	localparam int         DRAIN_CYCLES = 70;

	typedef struct {
		logic [3:0]  index;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [3:0]  nrounds;
		logic        err;
		logic        last_mark;
	} round_key_t;

	// predicts the round key schedule of each transferred key and checks results in order
	class key_schedule_board;
		logic [7:0] sbox_tab [0:255];
		round_key_t expected_round_keys [$];
		int fails;

		// build the s-box from the field inverse and the affine map
		function new();
			logic [7:0] p;
			logic [7:0] q;
			logic [7:0] x;
			fails = 0;
			p = 8'h01;
			q = 8'h01;
			do begin
				p = p ^ (p << 1) ^ (p[7] ? GF_POLY : 8'h00);
				q = q ^ (q << 1);
				q = q ^ (q << 2);
				q = q ^ (q << 4);
				if (q[7]) begin
					q = q ^ INV3_FIX;
				end
				x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]} ^ {q[3:0], q[7:4]};
				sbox_tab[p] = x ^ AFFINE_CONST;
			end while (p != 8'h01);
			sbox_tab[0] = AFFINE_CONST;
		endfunction

		function logic [31:0] sub_bytes(logic [31:0] v);
			return {sbox_tab[v[31:24]], sbox_tab[v[23:16]], sbox_tab[v[15:8]], sbox_tab[v[7:0]]};
		endfunction

		// expand one accepted key into its round keys
		function void expand_key(logic [1:0] size, logic [63:0] k0, logic [63:0] k1,
				logic [63:0] k2, logic [63:0] k3);
			logic [31:0] w [0:59];
			logic [31:0] t;
			logic [7:0]  rc;
			round_key_t  rk;
			int nk;
			int nr;
			if (size == aeske_pkg::SIZE_BAD) begin
				rk = '{index: 4'd0, hi: 64'd0, lo: 64'd0, nrounds: 4'd0, err: 1'b1, last_mark: 1'b1};
				expected_round_keys.push_back(rk);
				return;
			end
			nk = (size == aeske_pkg::SIZE_128) ? 4 : (size == aeske_pkg::SIZE_192) ? 6 : 8;
			nr = nk + 6;
			{w[0], w[1]} = k0;
			{w[2], w[3]} = k1;
			{w[4], w[5]} = k2;
			{w[6], w[7]} = k3;
			rc = RCON_FIRST;
			for (int i = nk; i < 4 * (nr + 1); i++) begin
				t = w[i - 1];
				if (i % nk == 0) begin
					t = sub_bytes({t[23:0], t[31:24]}) ^ {rc, 24'h0};
					rc = {rc[6:0], 1'b0} ^ (rc[7] ? GF_POLY : 8'h00);
				end else if (nk == 8 && i % nk == 4) begin
					t = sub_bytes(t);
				end
				w[i] = w[i - nk] ^ t;
			end
			for (int r = 0; r <= nr; r++) begin
				rk.index     = 4'(r);
				rk.hi        = {w[4 * r], w[4 * r + 1]};
				rk.lo        = {w[4 * r + 2], w[4 * r + 3]};
				rk.nrounds   = 4'(nr);
				rk.err       = 1'b0;
				rk.last_mark = (r == nr);
				expected_round_keys.push_back(rk);
			end
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				fails++;
			end
		endfunction

		// check one strobed result against the oldest expected round key
		function void check_round_key(logic [3:0] idx, logic [63:0] hi, logic [63:0] lo,
				logic [3:0] nrounds, logic err, logic last_mark);
			round_key_t rk;
			if (expected_round_keys.size() == 0) begin
				$error("round key with index %0d arrived with none expected", idx);
				fails++;
				return;
			end
			rk = expected_round_keys.pop_front();
			compare_field("round_index", 64'(rk.index), 64'(idx));
			compare_field("round_key_hi", rk.hi, hi);
			compare_field("round_key_lo", rk.lo, lo);
			compare_field("rounds", 64'(rk.nrounds), 64'(nrounds));
			compare_field("key_error", 64'(rk.err), 64'(err));
			compare_field("last", 64'(rk.last_mark), 64'(last_mark));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  key_size;
	logic [63:0] key_w0;
	logic [63:0] key_w1;
	logic [63:0] key_w2;
	logic [63:0] key_w3;
	logic        result_strobe;
	logic [3:0]  round_index;
	logic [63:0] round_key_hi;
	logic [63:0] round_key_lo;
	logic [3:0]  rounds;
	logic        key_error;
	logic        last;

	key_schedule_board sb = new();

	aes_key_expansion_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.key_size(key_size),
		.key_w0(key_w0),
		.key_w1(key_w1),
		.key_w2(key_w2),
		.key_w3(key_w3),
		.result_strobe(result_strobe),
		.round_index(round_index),
		.round_key_hi(round_key_hi),
		.round_key_lo(round_key_lo),
		.rounds(rounds),
		.key_error(key_error),
		.last(last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#3000000;
		$display("Test completed with failures");
		$finish;
	end

	// result monitor
	always @(posedge clk) begin
		if (result_strobe === 1'b1) begin
			sb.check_round_key(round_index, round_key_hi, round_key_lo, rounds, key_error, last);
		end
	end

	function automatic logic [63:0] rand_key_word();
		case ($urandom_range(0, 15))
			0: return 64'd0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// present one key and hold it until the transfer
	task automatic send_key(logic [1:0] size, logic [63:0] k0, logic [63:0] k1,
			logic [63:0] k2, logic [63:0] k3);
		start    <= 1'b1;
		key_size <= size;
		key_w0   <= k0;
		key_w1   <= k1;
		key_w2   <= k2;
		key_w3   <= k3;
		do begin
			@(posedge clk);
		end while (busy !== 1'b0);
		sb.expand_key(size, k0, k1, k2, k3);
	endtask

	// idle the sender with junk on the key fields
	task automatic pause_sender(int cycles);
		if (cycles > 0) begin
			start    <= 1'b0;
			key_size <= 2'($urandom_range(0, 3));
			key_w0   <= {$urandom, $urandom};
			key_w1   <= {$urandom, $urandom};
			key_w2   <= {$urandom, $urandom};
			key_w3   <= {$urandom, $urandom};
			repeat (cycles) @(posedge clk);
		end
	endtask

	// stimulus
	initial begin
		logic [1:0] size;
		int gap;
		int burst_left;
		arst_n   = 1'b0;
		start    = 1'b0;
		key_size = aeske_pkg::SIZE_128;
		key_w0   = 64'd0;
		key_w1   = 64'd0;
		key_w2   = 64'd0;
		key_w3   = 64'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// standard test keys
		send_key(aeske_pkg::SIZE_128, 64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 64'd0, 64'd0);
		send_key(aeske_pkg::SIZE_192, 64'h8e73b0f7da0e6452, 64'hc810f32b809079e5,
			64'h62f8ead2522c6b7b, 64'd0);
		pause_sender(2);
		send_key(aeske_pkg::SIZE_256, 64'h603deb1015ca71be, 64'h2b73aef0857d7781,
			64'h1f352c073b6108d7, 64'h2d9810a30914dff4);
		// all zero and all one keys
		send_key(aeske_pkg::SIZE_128, 64'd0, 64'd0, 64'd0, 64'd0);
		send_key(aeske_pkg::SIZE_192, 64'd0, 64'd0, 64'd0, 64'd0);
		pause_sender(1);
		send_key(aeske_pkg::SIZE_256, 64'd0, 64'd0, 64'd0, 64'd0);
		send_key(aeske_pkg::SIZE_128, '1, '1, '1, '1);
		send_key(aeske_pkg::SIZE_192, '1, '1, '1, '1);
		send_key(aeske_pkg::SIZE_256, '1, '1, '1, '1);
		// alternating bit patterns
		send_key(aeske_pkg::SIZE_128, {4{16'h5555}}, {4{16'haaaa}}, {4{16'h5555}},
			{4{16'haaaa}});
		pause_sender(3);
		send_key(aeske_pkg::SIZE_192, {4{16'haaaa}}, {4{16'h5555}}, {4{16'haaaa}},
			{4{16'h5555}});
		send_key(aeske_pkg::SIZE_256, {4{16'h5555}}, {4{16'haaaa}}, {4{16'haaaa}},
			{4{16'h5555}});
		// invalid size code, back to back, then a valid key right after
		send_key(aeske_pkg::SIZE_BAD, 64'd0, 64'd0, 64'd0, 64'd0);
		send_key(aeske_pkg::SIZE_BAD, '1, '1, '1, '1);
		send_key(aeske_pkg::SIZE_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'd0, 64'd0);
		pause_sender(1);
		send_key(aeske_pkg::SIZE_BAD, 64'h0123456789abcdef, 64'hfedcba9876543210, 64'd0, '1);
		// unused key words must not matter
		send_key(aeske_pkg::SIZE_128, 64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, '1,
			{4{16'h5a5a}});
		send_key(aeske_pkg::SIZE_192, 64'h8e73b0f7da0e6452, 64'hc810f32b809079e5,
			64'h62f8ead2522c6b7b, '1);

		// random keys in bursts
		burst_left = 0;
		for (int n = 0; n < RANDOM_KEYS; n++) begin
			if ($urandom_range(0, 9) == 0) begin
				size = aeske_pkg::SIZE_BAD;
			end else begin
				size = 2'($urandom_range(0, 2));
			end
			send_key(size, rand_key_word(), rand_key_word(), rand_key_word(), rand_key_word());
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 70) : $urandom_range(1, 6);
				burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 30)
					: $urandom_range(1, 6);
			end else begin
				gap = 0;
				burst_left--;
			end
			pause_sender(gap);
		end
		start <= 1'b0;

		// drain
		while (sb.expected_round_keys.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fails == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
